>>> rtl/core/dllce_pkg.sv
// ----------------------------------------------------------------------------
// dllce_pkg
// Shared opcodes, controller command bundle and default sizes for the
// linked list cursor engine.
// ----------------------------------------------------------------------------
package dllce_pkg;

	localparam int NODES_DEF      = 256;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int OPCODE_W       = 4;
	localparam int REPORT_W       = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_QUERY      = 4'd0,
		OP_CLEAR      = 4'd1,
		OP_INS_FIRST  = 4'd2,
		OP_INS_LAST   = 4'd3,
		OP_CUR_FIRST  = 4'd4,
		OP_CUR_LAST   = 4'd5,
		OP_DEL_FIRST  = 4'd6,
		OP_DEL_LAST   = 4'd7,
		OP_DEL_AFTER  = 4'd8,
		OP_DEL_BEFORE = 4'd9,
		OP_INS_AFTER  = 4'd10,
		OP_INS_BEFORE = 4'd11,
		OP_OVERWRITE  = 4'd12,
		OP_NEXT       = 4'd13,
		OP_PREV       = 4'd14
	} opcode_t;

	typedef struct packed {
		logic latch;    // take the incoming item
		logic take_a;   // first pointer reads are back
		logic wr_a;     // first write cycle
		logic wr_b;     // second write cycle, registers update
		logic load_out; // result goes to the output register
	} cmd_t;

endpackage

>>> rtl/core/dllce_ram.sv
// ----------------------------------------------------------------------------
// dllce_ram
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
module dllce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/dllce_ctrl.sv
// ----------------------------------------------------------------------------
// dllce_ctrl
// Command sequencer: steps each item through pointer reads, two write
// steps and the value read, and owns both handshakes.
// ----------------------------------------------------------------------------
module dllce_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output dllce_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDA,
		ST_RDB,
		ST_WRA,
		ST_WRB,
		ST_SETTLE,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.latch    = (state_q == ST_IDLE) && in_valid;
		cmd.take_a   = (state_q == ST_RDB);
		cmd.wr_a     = (state_q == ST_WRA);
		cmd.wr_b     = (state_q == ST_WRB);
		cmd.load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// in done the result register is reloaded instead
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RDA;
					end
				end
				ST_RDA:    state_q <= ST_RDB;
				ST_RDB:    state_q <= ST_WRA;
				ST_WRA:    state_q <= ST_WRB;
				ST_WRB:    state_q <= ST_SETTLE;
				ST_SETTLE: state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/dllce_dp.sv
// ----------------------------------------------------------------------------
// dllce_dp
// List datapath: node pointer and value memories, free stack, head, tail
// and cursor registers, relinking logic and the result register.
// ----------------------------------------------------------------------------
module dllce_dp #(
	parameter int NODES      = dllce_pkg::NODES_DEF,
	parameter int DATA_WIDTH = dllce_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dllce_pkg::cmd_t                     cmd,
	input  logic [dllce_pkg::OPCODE_W-1:0]      opcode,
	input  logic signed [dllce_pkg::REPORT_W-1:0] value,
	output logic                                status,
	output logic                                list_empty,
	output logic                                cursor_active,
	output logic [$clog2(NODES+1)-1:0]          element_count,
	output logic signed [dllce_pkg::REPORT_W-1:0] first_value,
	output logic signed [dllce_pkg::REPORT_W-1:0] last_value,
	output logic signed [dllce_pkg::REPORT_W-1:0] active_value
);

	localparam int AW = $clog2(NODES);
	localparam int IW = $clog2(NODES+1);
	localparam int RW = dllce_pkg::REPORT_W;
	localparam logic [IW-1:0] NIL = IW'(NODES);

	dllce_pkg::opcode_t op_q;
	logic [DATA_WIDTH-1:0] val_q;

	logic [IW-1:0] head_q, tail_q, cur_q, free_top_q, fresh_q, count_q;
	logic [IW-1:0] nx1_q, pv1_q, n_q;
	logic          alloc_ok_q, from_stk_q, status_q;

	// memory ports
	logic          nx_we, pv_we, fr_we, v_we;
	logic [AW-1:0] nx_wa, pv_wa, fr_wa, v_wa;
	logic [IW-1:0] nx_wd, pv_wd;
	logic [AW-1:0] fr_wd;
	logic [AW-1:0] nx_ra, pv_ra, fr_ra;
	logic [IW-1:0] nx_rd, pv_rd;
	logic [AW-1:0] fr_rd;
	logic [DATA_WIDTH-1:0] vh_rd, vt_rd, vc_rd;

	logic [IW-1:0] nx_addr_a, pv_addr_a, free_dec;
	logic h_ok, t_ok, c_ok, nx1_ok, pv1_ok, nx2_ok, pv2_ok;
	logic del8, del9, del_en, ins_en, ins_ok, push_ok;
	logic [IW-1:0] del_idx;

	assign h_ok   = head_q < NIL;
	assign t_ok   = tail_q < NIL;
	assign c_ok   = cur_q < NIL;
	assign nx1_ok = nx1_q < NIL;
	assign pv1_ok = pv1_q < NIL;
	assign nx2_ok = nx_rd < NIL;
	assign pv2_ok = pv_rd < NIL;
	assign del8   = c_ok && (cur_q != tail_q) && nx1_ok;
	assign del9   = c_ok && (cur_q != head_q) && pv1_ok;
	assign push_ok  = free_top_q < NIL;
	assign free_dec = free_top_q - IW'(1);

	always_comb begin
		del_en  = 1'b0;
		del_idx = head_q;
		ins_en  = 1'b0;
		case (op_q)
			dllce_pkg::OP_DEL_FIRST: begin
				del_en = h_ok;
			end
			dllce_pkg::OP_DEL_LAST: begin
				del_en  = t_ok;
				del_idx = tail_q;
			end
			dllce_pkg::OP_DEL_AFTER: begin
				del_en  = del8;
				del_idx = nx1_q;
			end
			dllce_pkg::OP_DEL_BEFORE: begin
				del_en  = del9;
				del_idx = pv1_q;
			end
			dllce_pkg::OP_INS_FIRST, dllce_pkg::OP_INS_LAST: ins_en = 1'b1;
			dllce_pkg::OP_INS_AFTER, dllce_pkg::OP_INS_BEFORE: ins_en = c_ok;
			default: ins_en = 1'b0;
		endcase
	end

	assign ins_ok = ins_en && alloc_ok_q;

	// first reads from the end pointers or the cursor, second reads chase the result
	assign nx_addr_a = (op_q == dllce_pkg::OP_DEL_FIRST) ? head_q : cur_q;
	assign pv_addr_a = (op_q == dllce_pkg::OP_DEL_LAST) ? tail_q : cur_q;
	assign nx_ra = cmd.take_a ? nx_rd[AW-1:0] : nx_addr_a[AW-1:0];
	assign pv_ra = cmd.take_a ? pv_rd[AW-1:0] : pv_addr_a[AW-1:0];
	assign fr_ra = free_dec[AW-1:0];

	always_comb begin
		nx_we = 1'b0;
		nx_wa = cur_q[AW-1:0];
		nx_wd = NIL;
		pv_we = 1'b0;
		pv_wa = cur_q[AW-1:0];
		pv_wd = NIL;
		fr_we = cmd.wr_a && del_en && push_ok;
		fr_wa = free_top_q[AW-1:0];
		fr_wd = del_idx[AW-1:0];
		v_we  = 1'b0;
		v_wa  = n_q[AW-1:0];
		if (cmd.wr_a) begin
			v_we = ins_ok;
			case (op_q)
				dllce_pkg::OP_INS_FIRST: begin
					nx_we = ins_ok;
					nx_wa = n_q[AW-1:0];
					nx_wd = head_q;
					pv_we = ins_ok;
					pv_wa = n_q[AW-1:0];
				end
				dllce_pkg::OP_INS_LAST: begin
					nx_we = ins_ok;
					nx_wa = n_q[AW-1:0];
					pv_we = ins_ok;
					pv_wa = n_q[AW-1:0];
					pv_wd = tail_q;
				end
				dllce_pkg::OP_DEL_FIRST: begin
					pv_we = del_en && nx1_ok;
					pv_wa = nx1_q[AW-1:0];
				end
				dllce_pkg::OP_DEL_LAST: begin
					nx_we = del_en && pv1_ok;
					nx_wa = pv1_q[AW-1:0];
				end
				dllce_pkg::OP_DEL_AFTER: begin
					nx_we = del8;
					nx_wd = nx_rd;
					pv_we = del8 && (nx1_q != tail_q) && nx2_ok;
					pv_wa = nx_rd[AW-1:0];
					pv_wd = cur_q;
				end
				dllce_pkg::OP_DEL_BEFORE: begin
					pv_we = del9;
					pv_wd = pv_rd;
					nx_we = del9 && (pv1_q != head_q) && pv2_ok;
					nx_wa = pv_rd[AW-1:0];
					nx_wd = cur_q;
				end
				dllce_pkg::OP_INS_AFTER: begin
					nx_we = ins_ok;
					nx_wa = n_q[AW-1:0];
					nx_wd = nx1_q;
					pv_we = ins_ok;
					pv_wa = n_q[AW-1:0];
					pv_wd = cur_q;
				end
				dllce_pkg::OP_INS_BEFORE: begin
					nx_we = ins_ok;
					nx_wa = n_q[AW-1:0];
					nx_wd = cur_q;
					pv_we = ins_ok;
					pv_wa = n_q[AW-1:0];
					pv_wd = pv1_q;
				end
				dllce_pkg::OP_OVERWRITE: begin
					v_we = c_ok;
					v_wa = cur_q[AW-1:0];
				end
				default: begin
					nx_we = 1'b0;
				end
			endcase
		end else if (cmd.wr_b) begin
			case (op_q)
				dllce_pkg::OP_INS_FIRST: begin
					pv_we = ins_ok && h_ok;
					pv_wa = head_q[AW-1:0];
					pv_wd = n_q;
				end
				dllce_pkg::OP_INS_LAST: begin
					nx_we = ins_ok && t_ok;
					nx_wa = tail_q[AW-1:0];
					nx_wd = n_q;
				end
				dllce_pkg::OP_INS_AFTER: begin
					nx_we = ins_ok;
					nx_wd = n_q;
					pv_we = ins_ok && (cur_q != tail_q) && nx1_ok;
					pv_wa = nx1_q[AW-1:0];
					pv_wd = n_q;
				end
				dllce_pkg::OP_INS_BEFORE: begin
					pv_we = ins_ok;
					pv_wd = n_q;
					nx_we = ins_ok && (cur_q != head_q) && pv1_ok;
					nx_wa = pv1_q[AW-1:0];
					nx_wd = n_q;
				end
				default: begin
					nx_we = 1'b0;
				end
			endcase
		end
	end

	dllce_ram #(.WIDTH(IW), .DEPTH(NODES)) u_next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
	);
	dllce_ram #(.WIDTH(IW), .DEPTH(NODES)) u_prev_ram (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd)
	);
	dllce_ram #(.WIDTH(AW), .DEPTH(NODES)) u_free_ram (
		.clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd)
	);

	// one value copy per report port, all written together
	dllce_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_val_head_ram (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(val_q),
		.raddr(head_q[AW-1:0]), .rdata(vh_rd)
	);
	dllce_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_val_tail_ram (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(val_q),
		.raddr(tail_q[AW-1:0]), .rdata(vt_rd)
	);
	dllce_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_val_cur_ram (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(val_q),
		.raddr(cur_q[AW-1:0]), .rdata(vc_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= NIL;
			tail_q     <= NIL;
			cur_q      <= NIL;
			free_top_q <= '0;
			fresh_q    <= '0;
			count_q    <= '0;
		end else if (cmd.wr_b) begin
			if (ins_ok) begin
				count_q <= count_q + IW'(1);
				if (from_stk_q) begin
					free_top_q <= free_dec;
				end else begin
					fresh_q <= fresh_q + IW'(1);
				end
			end
			if (del_en) begin
				if (push_ok) begin
					free_top_q <= free_top_q + IW'(1);
				end
				if (count_q != '0) begin
					count_q <= count_q - IW'(1);
				end
			end
			case (op_q)
				dllce_pkg::OP_CLEAR: begin
					head_q     <= NIL;
					tail_q     <= NIL;
					cur_q      <= NIL;
					free_top_q <= '0;
					fresh_q    <= '0;
					count_q    <= '0;
				end
				dllce_pkg::OP_INS_FIRST: begin
					if (ins_ok) begin
						if (!h_ok) begin
							tail_q <= n_q;
						end
						head_q <= n_q;
					end
				end
				dllce_pkg::OP_INS_LAST: begin
					if (ins_ok) begin
						if (!t_ok) begin
							head_q <= n_q;
						end
						tail_q <= n_q;
					end
				end
				dllce_pkg::OP_CUR_FIRST: cur_q <= h_ok ? head_q : NIL;
				dllce_pkg::OP_CUR_LAST:  cur_q <= t_ok ? tail_q : NIL;
				dllce_pkg::OP_DEL_FIRST: begin
					if (del_en) begin
						if (cur_q == head_q) begin
							cur_q <= NIL;
						end
						head_q <= nx1_q;
						if (!nx1_ok) begin
							tail_q <= NIL;
						end
					end
				end
				dllce_pkg::OP_DEL_LAST: begin
					if (del_en) begin
						if (cur_q == tail_q) begin
							cur_q <= NIL;
						end
						tail_q <= pv1_q;
						if (!pv1_ok) begin
							head_q <= NIL;
						end
					end
				end
				dllce_pkg::OP_DEL_AFTER: begin
					if (del8 && (nx1_q == tail_q)) begin
						tail_q <= cur_q;
					end
				end
				dllce_pkg::OP_DEL_BEFORE: begin
					if (del9 && (pv1_q == head_q)) begin
						head_q <= cur_q;
					end
				end
				dllce_pkg::OP_INS_AFTER: begin
					if (ins_ok && !((cur_q != tail_q) && nx1_ok)) begin
						tail_q <= n_q;
					end
				end
				dllce_pkg::OP_INS_BEFORE: begin
					if (ins_ok && !((cur_q != head_q) && pv1_ok)) begin
						head_q <= n_q;
					end
				end
				dllce_pkg::OP_NEXT: begin
					if (c_ok) begin
						cur_q <= nx1_ok ? nx1_q : NIL;
					end
				end
				dllce_pkg::OP_PREV: begin
					if (c_ok) begin
						cur_q <= pv1_ok ? pv1_q : NIL;
					end
				end
				default: begin
					cur_q <= cur_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= dllce_pkg::opcode_t'(opcode);
			val_q <= DATA_WIDTH'(value);
		end
		if (cmd.take_a) begin
			nx1_q <= nx_rd;
			pv1_q <= pv_rd;
			// reuse a freed node before touching a fresh one
			if (free_top_q != '0) begin
				n_q        <= IW'(fr_rd);
				from_stk_q <= 1'b1;
				alloc_ok_q <= 1'b1;
			end else begin
				n_q        <= fresh_q;
				from_stk_q <= 1'b0;
				alloc_ok_q <= fresh_q < NIL;
			end
		end
		if (cmd.wr_b) begin
			status_q <= ins_en && !alloc_ok_q;
		end
		if (cmd.load_out) begin
			status        <= status_q;
			list_empty    <= !h_ok;
			cursor_active <= c_ok;
			element_count <= count_q;
			first_value   <= h_ok ? RW'(signed'(vh_rd)) : '0;
			last_value    <= t_ok ? RW'(signed'(vt_rd)) : '0;
			active_value  <= c_ok ? RW'(signed'(vc_rd)) : '0;
		end
	end

endmodule

>>> rtl/core/doubly_linked_list_cursor_engine.sv
// Items are taken one at a time: the next is accepted only after the previous one has
// passed the pointer memories: a neighbour read, a dependent read of its neighbour,
// two write steps for relinking, then one value memory read.
// A new item is taken while the previous result still waits in the output register.
// Reset: head, tail and cursor go to null, counters to zero; node memories are
// not cleared and there is no clearing pass.
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor_engine
// Doubly linked list with cursor over a fixed node pool, one result per item.
// ----------------------------------------------------------------------------
module doubly_linked_list_cursor_engine #(
	parameter int NODES      = dllce_pkg::NODES_DEF,
	parameter int DATA_WIDTH = dllce_pkg::DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [dllce_pkg::OPCODE_W-1:0]        opcode,
	input  logic signed [dllce_pkg::REPORT_W-1:0] value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  status,
	output logic                                  list_empty,
	output logic                                  cursor_active,
	output logic [$clog2(NODES+1)-1:0]            element_count,
	output logic signed [dllce_pkg::REPORT_W-1:0] first_value,
	output logic signed [dllce_pkg::REPORT_W-1:0] last_value,
	output logic signed [dllce_pkg::REPORT_W-1:0] active_value
);

	dllce_pkg::cmd_t cmd;

	dllce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	dllce_dp #(
		.NODES      (NODES),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (opcode),
		.value         (value),
		.status        (status),
		.list_empty    (list_empty),
		.cursor_active (cursor_active),
		.element_count (element_count),
		.first_value   (first_value),
		.last_value    (last_value),
		.active_value  (active_value)
	);

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives list commands into the cursor engine, a directed table first, then random
// command streams, including a pool filled to the last node, under several idle
// and stall patterns. Every result is checked against a behavioural model of the
// node pool, or against the written expectation of a directed row that has one.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dllce_pkg::*;

	localparam int POOL = 256;
	localparam int NIL = POOL;
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 4'd15;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic               status;
		logic               empty;
		logic               active;
		logic [8:0]         count;
		logic signed [31:0] first;
		logic signed [31:0] last;
		logic signed [31:0] act;
	} list_result_t;

	typedef struct {
		logic [OPCODE_W-1:0] op;
		logic signed [31:0]  val;
		bit                  has_exp;
		list_result_t        exp;
	} cmd_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [OPCODE_W-1:0]        opcode = '0;
	logic signed [REPORT_W-1:0] value = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       status, list_empty, cursor_active;
	logic [8:0]                 element_count;
	logic signed [REPORT_W-1:0] first_value, last_value, active_value;

	doubly_linked_list_cursor_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .value(value),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.list_empty(list_empty), .cursor_active(cursor_active),
		.element_count(element_count), .first_value(first_value),
		.last_value(last_value), .active_value(active_value)
	);

	always #10 clk = ~clk;

	// model of the node pool
	logic signed [31:0] node_val[POOL];
	int node_nxt[POOL];
	int node_prv[POOL];
	int free_stk[POOL];
	int head_i = NIL, tail_i = NIL, cur_i = NIL;
	int free_top = 0, fresh_cnt = 0, elem_cnt = 0;

	list_result_t pending_results[$];
	bit           typed_flag = 0;
	list_result_t typed_exp;

	int send_idle_pct = 0, recv_stall_pct = 0;
	int n_items = 0, n_results = 0, n_errors = 0, n_full = 0, peak_count = 0;
	int quiet_cycles = 0;

	function automatic bit take_node(output int n);
		if (free_top > 0) begin
			free_top--;
			n = free_stk[free_top];
			return 1;
		end
		if (fresh_cnt < POOL) begin
			n = fresh_cnt++;
			return 1;
		end
		return 0;
	endfunction

	function automatic void drop_node(int t);
		free_stk[free_top++] = t;
		elem_cnt--;
	endfunction

	function automatic list_result_t apply_command(logic [3:0] op, logic signed [31:0] v);
		list_result_t r;
		int n, t;
		int c = cur_i;
		r.status = 0;
		case (op)
			OP_CLEAR: begin
				head_i = NIL; tail_i = NIL; cur_i = NIL;
				free_top = 0; fresh_cnt = 0; elem_cnt = 0;
			end
			OP_INS_FIRST, OP_INS_LAST: begin
				if (!take_node(n)) r.status = 1;
				else begin
					node_val[n] = v;
					elem_cnt++;
					if (op == OP_INS_FIRST) begin
						node_nxt[n] = head_i; node_prv[n] = NIL;
						if (head_i != NIL) node_prv[head_i] = n;
						else tail_i = n;
						head_i = n;
					end else begin
						node_prv[n] = tail_i; node_nxt[n] = NIL;
						if (tail_i != NIL) node_nxt[tail_i] = n;
						else head_i = n;
						tail_i = n;
					end
				end
			end
			OP_CUR_FIRST: cur_i = head_i;
			OP_CUR_LAST:  cur_i = tail_i;
			OP_DEL_FIRST: if (head_i != NIL) begin
				t = head_i;
				if (cur_i == t) cur_i = NIL;
				head_i = node_nxt[t];
				if (head_i != NIL) node_prv[head_i] = NIL;
				else tail_i = NIL;
				drop_node(t);
			end
			OP_DEL_LAST: if (tail_i != NIL) begin
				t = tail_i;
				if (cur_i == t) cur_i = NIL;
				tail_i = node_prv[t];
				if (tail_i != NIL) node_nxt[tail_i] = NIL;
				else head_i = NIL;
				drop_node(t);
			end
			OP_DEL_AFTER: if (c != NIL && c != tail_i) begin
				t = node_nxt[c];
				node_nxt[c] = node_nxt[t];
				if (t == tail_i) tail_i = c;
				else node_prv[node_nxt[t]] = c;
				drop_node(t);
			end
			OP_DEL_BEFORE: if (c != NIL && c != head_i) begin
				t = node_prv[c];
				node_prv[c] = node_prv[t];
				if (t == head_i) head_i = c;
				else node_nxt[node_prv[t]] = c;
				drop_node(t);
			end
			OP_INS_AFTER, OP_INS_BEFORE: if (c != NIL) begin
				if (!take_node(n)) r.status = 1;
				else begin
					node_val[n] = v;
					elem_cnt++;
					if (op == OP_INS_AFTER) begin
						node_prv[n] = c; node_nxt[n] = node_nxt[c]; node_nxt[c] = n;
						if (c != tail_i) node_prv[node_nxt[n]] = n;
						else tail_i = n;
					end else begin
						node_nxt[n] = c; node_prv[n] = node_prv[c]; node_prv[c] = n;
						if (c != head_i) node_nxt[node_prv[n]] = n;
						else head_i = n;
					end
				end
			end
			OP_OVERWRITE: if (c != NIL) node_val[c] = v;
			OP_NEXT:      if (c != NIL) cur_i = node_nxt[c];
			OP_PREV:      if (c != NIL) cur_i = node_prv[c];
			default: ;
		endcase
		r.empty  = (head_i == NIL);
		r.active = (cur_i != NIL);
		r.count  = elem_cnt[8:0];
		r.first  = (head_i != NIL) ? node_val[head_i] : '0;
		r.last   = (tail_i != NIL) ? node_val[tail_i] : '0;
		r.act    = (cur_i != NIL) ? node_val[cur_i] : '0;
		return r;
	endfunction

	// input side: predict on each accepted item, watchdog on quiet cycles
	always @(posedge clk) begin
		list_result_t r;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				r = apply_command(opcode, value);
				if (r.status) n_full++;
				if (elem_cnt > peak_count) peak_count = elem_cnt;
				pending_results.push_back(typed_flag ? typed_exp : r);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// output side: compare against the oldest expectation
	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("result %0d arrived with nothing expected", n_results);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status || list_empty !== e.empty || cursor_active !== e.active
						|| element_count !== e.count || first_value !== e.first
						|| last_value !== e.last || active_value !== e.act) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("result %0d: exp st=%0b em=%0b ac=%0b n=%0d f=%0d l=%0d a=%0d",
							n_results, e.status, e.empty, e.active, e.count, e.first,
							e.last, e.act);
						$display("result %0d: got st=%0b em=%0b ac=%0b n=%0d f=%0d l=%0d a=%0d",
							n_results, status, list_empty, cursor_active, element_count,
							first_value, last_value, active_value);
					end
				end
			end
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	task automatic send_item(logic [3:0] op, logic signed [31:0] v, bit has_exp, list_result_t exp);
		in_valid   <= 1'b1;
		opcode     <= op;
		value      <= v;
		typed_flag <= has_exp;
		typed_exp  <= exp;
		do @(posedge clk); while (in_stall);
		n_items++;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_cmd(logic [3:0] op, logic signed [31:0] v);
		list_result_t none;
		none = '{default: '0};
		send_item(op, v, 0, none);
	endtask

	task automatic set_idling(int k);
		case (k % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
			default: begin send_idle_pct = 14; recv_stall_pct = 14; end
		endcase
	endtask

	function automatic logic [3:0] pick_op();
		int w = $urandom_range(99);
		if (w < 40) return 4'(OP_INS_FIRST + $urandom_range(0, 1) + (w % 2) * 8);
		if (w < 60) return 4'(OP_DEL_FIRST + $urandom_range(0, 3));
		if (w < 88) begin
			case ($urandom_range(0, 4))
				0: return OP_CUR_FIRST;
				1: return OP_CUR_LAST;
				2: return OP_NEXT;
				3: return OP_PREV;
				default: return OP_OVERWRITE;
			endcase
		end
		if (w < 92) return OP_QUERY;
		if (w < 95) return OP_UNUSED;
		if (w < 97) return OP_CLEAR;
		return OP_CUR_FIRST;
	endfunction

	cmd_row_t directed[$];

	function automatic cmd_row_t row(logic [3:0] op, logic signed [31:0] v);
		cmd_row_t r;
		r.op = op; r.val = v; r.has_exp = 0;
		r.exp = '{default: '0};
		return r;
	endfunction

	function automatic cmd_row_t row_exp(logic [3:0] op, logic signed [31:0] v, logic em,
			logic ac, int n, logic signed [31:0] f, logic signed [31:0] l, logic signed [31:0] a);
		cmd_row_t r;
		r = row(op, v);
		r.has_exp = 1;
		r.exp = '{status: 1'b0, empty: em, active: ac, count: n[8:0], first: f, last: l, act: a};
		return r;
	endfunction

	initial begin
		logic signed [31:0] maxv = 32'sh7fffffff;
		logic signed [31:0] minv = 32'sh80000000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(row_exp(OP_QUERY, 0, 1, 0, 0, 0, 0, 0));
		directed.push_back(row_exp(OP_INS_FIRST, maxv, 0, 0, 1, maxv, maxv, 0));
		directed.push_back(row_exp(OP_INS_LAST, minv, 0, 0, 2, maxv, minv, 0));
		directed.push_back(row_exp(OP_CUR_FIRST, 0, 0, 1, 2, maxv, minv, maxv));
		directed.push_back(row(OP_INS_AFTER, 0));
		directed.push_back(row(OP_INS_BEFORE, -1));
		directed.push_back(row(OP_OVERWRITE, 5));
		directed.push_back(row(OP_NEXT, 0));
		directed.push_back(row(OP_PREV, 0));
		directed.push_back(row(OP_DEL_AFTER, 0));
		directed.push_back(row(OP_DEL_BEFORE, 0));
		// deleting before the head has nothing to remove
		directed.push_back(row(OP_DEL_BEFORE, 0));
		directed.push_back(row(OP_CUR_LAST, 0));
		directed.push_back(row(OP_DEL_AFTER, 0));
		directed.push_back(row(OP_UNUSED, 32'sh12345678));
		directed.push_back(row(OP_NEXT, 0));
		directed.push_back(row(OP_CUR_FIRST, 0));
		directed.push_back(row(OP_DEL_FIRST, 0));
		directed.push_back(row(OP_DEL_LAST, 0));
		directed.push_back(row_exp(OP_CLEAR, 0, 1, 0, 0, 0, 0, 0));
		directed.push_back(row_exp(OP_DEL_FIRST, 0, 1, 0, 0, 0, 0, 0));
		directed.push_back(row_exp(OP_CUR_LAST, 0, 1, 0, 0, 0, 0, 0));
		directed.push_back(row_exp(OP_INS_AFTER, 1, 1, 0, 0, 0, 0, 0));
		directed.push_back(row_exp(OP_OVERWRITE, 1, 1, 0, 0, 0, 0, 0));
		foreach (directed[i])
			send_item(directed[i].op, directed[i].val, directed[i].has_exp, directed[i].exp);

		// hold off until the engine has drained
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);

		// fill the pool past the last node, then churn the free stack
		set_idling(3);
		send_cmd(OP_INS_LAST, $urandom);
		send_cmd(OP_CUR_FIRST, 0);
		for (int i = 0; i < 262; i++) begin
			if (i == 130) set_idling(2);
			send_cmd(4'(OP_INS_FIRST + $urandom_range(0, 1) + 8 * $urandom_range(0, 1)),
				$urandom);
		end

		for (int i = 0; i < 420; i++) begin
			if (i % 105 == 0) set_idling(i / 105);
			send_cmd(pick_op(), $urandom);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d commands, %0d results, %0d inserts refused on a full pool, peak %0d elements",
			n_items, n_results, n_full, peak_count);
		if (n_errors == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
